### rtl/ctl_pkg.sv
`timescale 1ns / 1ps

package ctl_pkg;

    localparam int BYTE_W     = 8;
    localparam int CLASS_W    = 3;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Characters with a special role
    localparam logic [BYTE_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CH_SLASH      = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR       = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_NEWLINE    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_BACKSLASH  = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SQUOTE     = 8'h27;
    localparam logic [BYTE_W-1:0] CH_DQUOTE     = 8'h22;

    // Token classes as carried on the output channel
    typedef enum logic [CLASS_W-1:0] {
        CLASS_NUMBER   = 3'd0,
        CLASS_WORD     = 3'd1,
        CLASS_PUNCT    = 3'd2,
        CLASS_OPERATOR = 3'd3,
        CLASS_LITERAL  = 3'd4,
        CLASS_SLASH    = 3'd5,
        CLASS_ILLEGAL  = 3'd6
    } t_class;

    // Lexer modes, one-hot
    typedef enum logic [8:0] {
        MODE_IDLE  = 9'b000000001,
        MODE_NUM   = 9'b000000010,
        MODE_WORD  = 9'b000000100,
        MODE_OP    = 9'b000001000,
        MODE_SLASH = 9'b000010000,
        MODE_LINE  = 9'b000100000,
        MODE_BLOCK = 9'b001000000,
        MODE_BSTAR = 9'b010000000,
        MODE_LIT   = 9'b100000000
    } t_mode;

    typedef struct packed {
        t_mode             mode;
        logic              quote_is_double;
        logic              escape_pending;
        logic [BYTE_W-1:0] operator_char;
    } t_lex_state;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              starts_token;
        t_class            token_class;
        logic              last_of_run;
    } t_result;

    localparam t_lex_state LEX_RESET = '{
        mode:            MODE_IDLE,
        quote_is_double: 1'b0,
        escape_pending:  1'b0,
        operator_char:   '0
    };

endpackage

### rtl/ctl_in_if.sv
`timescale 1ns / 1ps

interface ctl_in_if;
    logic                         valid;
    logic                         ready;
    logic [ctl_pkg::BYTE_W-1:0]   in_byte;
    logic                         end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

### rtl/ctl_out_if.sv
`timescale 1ns / 1ps

interface ctl_out_if;
    logic                         valid;
    logic                         ready;
    logic [ctl_pkg::BYTE_W-1:0]   out_byte;
    logic                         starts_token;
    logic [ctl_pkg::CLASS_W-1:0]  token_class;
    logic                         last_of_run;

    modport source (output valid, output out_byte, output starts_token,
                    output token_class, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input starts_token,
                    input token_class, input last_of_run, output ready);
endinterface

### rtl/ctl_step.sv
`timescale 1ns / 1ps

// One lexer step: current state and one byte in, next state and up to two results out.
module ctl_step (
    input  ctl_pkg::t_lex_state          i_state,
    input  logic [ctl_pkg::BYTE_W-1:0]   i_byte,
    input  logic                         i_end,
    output ctl_pkg::t_lex_state          o_state,
    output logic [1:0]                   o_count,
    output ctl_pkg::t_result             o_res0,
    output ctl_pkg::t_result             o_res1
);
    import ctl_pkg::*;

    function automatic logic is_digit(input logic [BYTE_W-1:0] b);
        is_digit = (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [BYTE_W-1:0] b);
        is_alpha = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic logic is_wordch(input logic [BYTE_W-1:0] b);
        is_wordch = is_alpha(b) || is_digit(b) || (b == CH_UNDERSCORE);
    endfunction

    // Token start decode, independent of the current mode
    logic       st_emit;
    t_class     st_class;
    t_mode      st_mode;
    logic       st_is_op;
    logic       st_is_quote;

    always_comb begin
        st_emit     = 1'b1;
        st_class    = CLASS_ILLEGAL;
        st_mode     = MODE_IDLE;
        st_is_op    = 1'b0;
        st_is_quote = 1'b0;
        case (i_byte)
            8'h09, 8'h0A, 8'h0D, 8'h20: begin
                st_emit = 1'b0;
            end
            8'h23, 8'h3C, 8'h3E, 8'h2E, 8'h2C, 8'h2A, 8'h3D, 8'h21,
            8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h3B, 8'h5C: begin
                st_class = CLASS_PUNCT;
            end
            8'h2B, 8'h2D, 8'h3A, 8'h7C, 8'h26: begin
                st_class = CLASS_OPERATOR;
                st_mode  = MODE_OP;
                st_is_op = 1'b1;
            end
            CH_SLASH: begin
                st_emit = 1'b0;
                st_mode = MODE_SLASH;
            end
            CH_SQUOTE, CH_DQUOTE: begin
                st_class    = CLASS_LITERAL;
                st_mode     = MODE_LIT;
                st_is_quote = 1'b1;
            end
            default: begin
                if (is_digit(i_byte)) begin
                    st_class = CLASS_NUMBER;
                    st_mode  = MODE_NUM;
                end else if (is_wordch(i_byte)) begin
                    st_class = CLASS_WORD;
                    st_mode  = MODE_WORD;
                end
            end
        endcase
    end

    // Mode update and result selection
    logic       do_start;
    logic       emit0;
    logic       emit1;
    t_result    res0;
    t_result    res1;
    t_lex_state nxt;

    always_comb begin
        nxt      = i_state;
        do_start = 1'b0;
        emit0    = 1'b0;
        emit1    = 1'b0;
        res0     = '{out_byte: i_byte, starts_token: 1'b0, token_class: CLASS_NUMBER,
                     last_of_run: 1'b0};
        res1     = res0;

        if (i_end) begin
            // flush a held slash, then back to reset state
            emit0             = (i_state.mode == MODE_SLASH);
            res0.out_byte     = CH_SLASH;
            res0.starts_token = 1'b1;
            res0.token_class  = CLASS_SLASH;
            nxt               = LEX_RESET;
        end else begin
            case (i_state.mode)
                MODE_NUM: begin
                    if (is_digit(i_byte)) begin
                        emit0            = 1'b1;
                        res0.token_class = CLASS_NUMBER;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (is_wordch(i_byte)) begin
                        emit0            = 1'b1;
                        res0.token_class = CLASS_WORD;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                MODE_OP: begin
                    if (i_byte == i_state.operator_char) begin
                        emit0            = 1'b1;
                        res0.token_class = CLASS_OPERATOR;
                        nxt.mode         = MODE_IDLE;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                MODE_SLASH: begin
                    if (i_byte == CH_SLASH) begin
                        nxt.mode = MODE_LINE;
                    end else if (i_byte == CH_STAR) begin
                        nxt.mode = MODE_BLOCK;
                    end else begin
                        // held slash goes out first, then the byte starts a token
                        emit0             = 1'b1;
                        res0.out_byte     = CH_SLASH;
                        res0.starts_token = 1'b1;
                        res0.token_class  = CLASS_SLASH;
                        do_start          = 1'b1;
                    end
                end
                MODE_LINE: begin
                    if (i_byte == CH_NEWLINE) begin
                        nxt.mode = MODE_IDLE;
                    end
                end
                MODE_BLOCK: begin
                    if (i_byte == CH_STAR) begin
                        nxt.mode = MODE_BSTAR;
                    end
                end
                MODE_BSTAR: begin
                    if (i_byte == CH_SLASH) begin
                        nxt.mode = MODE_IDLE;
                    end else if (i_byte != CH_STAR) begin
                        nxt.mode = MODE_BLOCK;
                    end
                end
                MODE_LIT: begin
                    emit0            = 1'b1;
                    res0.token_class = CLASS_LITERAL;
                    if (i_state.escape_pending) begin
                        nxt.escape_pending = 1'b0;
                    end else if (i_byte == CH_BACKSLASH) begin
                        nxt.escape_pending = 1'b1;
                    end else if (i_byte == (i_state.quote_is_double ? CH_DQUOTE : CH_SQUOTE)) begin
                        nxt.mode = MODE_IDLE;
                    end
                end
                default: begin
                    do_start = 1'b1;
                end
            endcase

            if (do_start) begin
                nxt.mode = st_mode;
                if (st_is_op) begin
                    nxt.operator_char = i_byte;
                end
                if (st_is_quote) begin
                    nxt.quote_is_double = (i_byte == CH_DQUOTE);
                    nxt.escape_pending  = 1'b0;
                end
                // start result goes second when a slash was flushed ahead of it
                if (emit0) begin
                    emit1             = st_emit;
                    res1.starts_token = 1'b1;
                    res1.token_class  = st_class;
                end else begin
                    emit0             = st_emit;
                    res0.starts_token = 1'b1;
                    res0.token_class  = st_class;
                end
            end
        end

        res0.last_of_run = !emit1;
        res1.last_of_run = 1'b1;
    end

    assign o_state = nxt;
    assign o_count = emit1 ? 2'd2 : {1'b0, emit0};
    assign o_res0  = res0;
    assign o_res1  = res1;

endmodule

### rtl/c_style_token_lexer_top.sv
`timescale 1ns / 1ps
// C-style token lexer.
// Input channel i_in carries one source byte per request (in_byte) and an
// end_of_input flag; a request with the flag set flushes a held slash and
// returns the lexer to its idle state, its byte is ignored.
// Output channel o_out carries one token byte per request with its
// starts_token flag, token_class and last_of_run, which marks the final
// result caused by an input request. An input request causes zero, one or
// two results (two when a held slash is released ahead of a new token).
// Latency: a result passes through the input register, then the lexer step
// into a four-entry result queue, before it is presented on o_out.
// Throughput: one input request per cycle while two queue slots are free, set
// by the combinational lexer step; the output drains one result per cycle while
// the receiver is ready, so sustained runs of two-result inputs are limited by the output side.
// A stalled receiver fills the result queue; the input register holds its
// byte while fewer than two queue slots are free, and i_in.ready drops
// once that register is occupied and cannot advance.
// Reset (i_rst_n low, synchronous) empties the queue and input register
// and puts the lexer in its idle state.
module c_style_token_lexer_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    ctl_in_if.sink   i_in,
    ctl_out_if.source o_out
);
    import ctl_pkg::*;

    // Input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;

    // Lexer state
    t_lex_state r_state;
    t_lex_state n_state;

    // Result queue
    t_result           r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic [1:0] step_count;
    t_result    step_res0;
    t_result    step_res1;
    logic       advance;
    logic       in_take;
    logic       out_take;
    t_result    head;

    ctl_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_state (n_state),
        .o_count (step_count),
        .o_res0  (step_res0),
        .o_res1  (step_res1)
    );

    // Handshake control: step fires when two queue slots are free
    assign advance    = r_in_valid && (r_count <= CNT_W'(FIFO_DEPTH - 2));
    assign i_in.ready = !r_in_valid || advance;
    assign in_take    = i_in.valid && i_in.ready;
    assign out_take   = o_out.valid && o_out.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_take) begin
            r_in_byte <= i_in.in_byte;
            r_in_end  <= i_in.end_of_input;
        end
    end

    // Lexer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LEX_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result queue write and pointers
    always_comb begin
        n_count = r_count + (advance ? CNT_W'(step_count) : '0) - CNT_W'(out_take);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (advance) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(step_count);
            end
            if (out_take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
        if (advance && (step_count != 2'd0)) begin
            r_fifo[r_wr_ptr] <= step_res0;
        end
        if (advance && (step_count == 2'd2)) begin
            r_fifo[r_wr_ptr + 1'b1] <= step_res1;
        end
    end

    // Output channel from the queue head
    assign head               = r_fifo[r_rd_ptr];
    assign o_out.valid        = (r_count != '0);
    assign o_out.out_byte     = head.out_byte;
    assign o_out.starts_token = head.starts_token;
    assign o_out.token_class  = head.token_class;
    assign o_out.last_of_run  = head.last_of_run;

endmodule

### test/tb_c_style_token_lexer_top.sv
`timescale 1ns / 1ps

module tb_c_style_token_lexer_top;
    import ctl_pkg::*;

    localparam int HOLD_CYCLES = 48;
    localparam int TAIL_CYCLES = 8;

    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

    // Bytes that form single-character tokens and operator starts
    localparam string PUNCT_SET = "#<>.,*=!()[]{};\\";
    localparam string OPER_SET  = "+-:|&";
    localparam string WORD_SET  =
        "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    typedef struct {
        logic [BYTE_W-1:0] ch;
        logic              eoi;
    } t_src_item;

    // Token stream predictor plus the queue of tokens still owed by the block
    class lexer_scoreboard;
        t_result           awaited_tokens[$];
        t_result           step_tokens[$];
        t_mode             mode;
        logic              dq_quote;
        logic              esc_armed;
        logic [BYTE_W-1:0] op_byte;
        int                mismatches;
        int                requests;
        int                checked;

        function new();
            clear_state();
            mismatches = 0;
            requests   = 0;
            checked    = 0;
        endfunction

        function void clear_state();
            mode      = MODE_IDLE;
            dq_quote  = 1'b0;
            esc_armed = 1'b0;
            op_byte   = '0;
        endfunction

        function bit is_digit(logic [BYTE_W-1:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_word_char(logic [BYTE_W-1:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
                   is_digit(c) || c == CH_UNDERSCORE;
        endfunction

        function void add_token(logic [BYTE_W-1:0] c, logic first, t_class cls);
            t_result r;
            if (step_tokens.size() >= 2) return;
            r.out_byte     = c;
            r.starts_token = first;
            r.token_class  = cls;
            r.last_of_run  = 1'b0;
            step_tokens.insert(step_tokens.size(), r);
        endfunction

        // Lex a byte from idle (also used when a run ends on a foreign byte)
        function void open_token(logic [BYTE_W-1:0] c);
            mode = MODE_IDLE;
            case (c)
                CH_TAB, CH_NEWLINE, CH_CR, CH_SPACE: ;
                "#", "<", ">", ".", ",", CH_STAR, "=", "!", "(", ")",
                "[", "]", "{", "}", ";", CH_BACKSLASH:
                    add_token(c, 1'b1, CLASS_PUNCT);
                "+", "-", ":", "|", "&": begin
                    add_token(c, 1'b1, CLASS_OPERATOR);
                    mode    = MODE_OP;
                    op_byte = c;
                end
                CH_SLASH:
                    mode = MODE_SLASH;
                CH_SQUOTE, CH_DQUOTE: begin
                    add_token(c, 1'b1, CLASS_LITERAL);
                    mode      = MODE_LIT;
                    dq_quote  = (c == CH_DQUOTE);
                    esc_armed = 1'b0;
                end
                default: begin
                    if (is_digit(c)) begin
                        add_token(c, 1'b1, CLASS_NUMBER);
                        mode = MODE_NUM;
                    end else if (is_word_char(c)) begin
                        add_token(c, 1'b1, CLASS_WORD);
                        mode = MODE_WORD;
                    end else begin
                        add_token(c, 1'b1, CLASS_ILLEGAL);
                    end
                end
            endcase
        endfunction

        // One accepted request: advance the lexer and queue what it owes
        function void take_byte(logic [BYTE_W-1:0] c, logic eoi);
            step_tokens.delete();
            requests++;
            if (eoi) begin
                if (mode == MODE_SLASH) add_token(CH_SLASH, 1'b1, CLASS_SLASH);
                clear_state();
            end else begin
                case (mode)
                    MODE_NUM:
                        if (is_digit(c)) add_token(c, 1'b0, CLASS_NUMBER);
                        else open_token(c);
                    MODE_WORD:
                        if (is_word_char(c)) add_token(c, 1'b0, CLASS_WORD);
                        else open_token(c);
                    MODE_OP:
                        if (c == op_byte) begin
                            add_token(c, 1'b0, CLASS_OPERATOR);
                            mode = MODE_IDLE;
                        end else begin
                            open_token(c);
                        end
                    MODE_SLASH:
                        if (c == CH_SLASH) mode = MODE_LINE;
                        else if (c == CH_STAR) mode = MODE_BLOCK;
                        else begin
                            add_token(CH_SLASH, 1'b1, CLASS_SLASH);
                            open_token(c);
                        end
                    MODE_LINE:
                        if (c == CH_NEWLINE) mode = MODE_IDLE;
                    MODE_BLOCK:
                        if (c == CH_STAR) mode = MODE_BSTAR;
                    MODE_BSTAR:
                        if (c == CH_SLASH) mode = MODE_IDLE;
                        else if (c != CH_STAR) mode = MODE_BLOCK;
                    MODE_LIT: begin
                        add_token(c, 1'b0, CLASS_LITERAL);
                        if (esc_armed) esc_armed = 1'b0;
                        else if (c == CH_BACKSLASH) esc_armed = 1'b1;
                        else if (c == (dq_quote ? CH_DQUOTE : CH_SQUOTE))
                            mode = MODE_IDLE;
                    end
                    default:
                        open_token(c);
                endcase
            end
            if (step_tokens.size() > 0)
                step_tokens[step_tokens.size()-1].last_of_run = 1'b1;
            foreach (step_tokens[i])
                awaited_tokens.insert(awaited_tokens.size(), step_tokens[i]);
        endfunction

        task report_mismatch(string what, int unsigned want, int unsigned seen);
            mismatches++;
            $display("%0t ns: mismatch on %s: expected 'h%0h, got 'h%0h",
                     $realtime, what, want, seen);
        endtask

        task check_token(t_result seen);
            t_result want;
            checked++;
            if (awaited_tokens.size() == 0) begin
                report_mismatch("unexpected token byte", 0, seen.out_byte);
                return;
            end
            want = awaited_tokens.pop_front();
            if (seen.out_byte !== want.out_byte)
                report_mismatch("out_byte", want.out_byte, seen.out_byte);
            if (seen.starts_token !== want.starts_token)
                report_mismatch("starts_token", want.starts_token, seen.starts_token);
            if (seen.token_class !== want.token_class)
                report_mismatch("token_class", want.token_class, seen.token_class);
            if (seen.last_of_run !== want.last_of_run)
                report_mismatch("last_of_run", want.last_of_run, seen.last_of_run);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    ctl_in_if  in_if();
    ctl_out_if out_if();

    c_style_token_lexer_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    lexer_scoreboard sb = new();
    t_src_item       src_q[$];
    bit              tx_calm;
    bit              rx_calm;
    bit              hold_req;
    t_result         seen_token;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Queue one source byte for the sender
    function automatic void queue_byte(logic [BYTE_W-1:0] c, logic eoi);
        t_src_item it;
        it.ch  = c;
        it.eoi = eoi;
        src_q.insert(src_q.size(), it);
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i], 1'b0);
    endfunction

    function automatic logic [BYTE_W-1:0] pick(string s);
        return s[$urandom_range(0, s.len() - 1)];
    endfunction

    // Append one mostly well-formed source fragment with random content
    function automatic void add_fragment();
        int                kind;
        int                n;
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] q;
        kind = $urandom_range(0, 99);
        if (kind < 12) begin
            n = $urandom_range(1, 6);
            repeat (n) queue_byte(8'($urandom_range("0", "9")), 1'b0);
        end else if (kind < 26) begin
            queue_byte(pick(WORD_SET.substr(0, 52)), 1'b0);
            n = $urandom_range(0, 7);
            repeat (n) queue_byte(pick(WORD_SET), 1'b0);
        end else if (kind < 34) begin
            c = pick(OPER_SET);
            n = $urandom_range(1, 3);
            repeat (n) queue_byte(c, 1'b0);
        end else if (kind < 42) begin
            queue_byte(pick(PUNCT_SET), 1'b0);
        end else if (kind < 50) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0: queue_byte(CH_TAB, 1'b0);
                    1: queue_byte(CH_NEWLINE, 1'b0);
                    2: queue_byte(CH_CR, 1'b0);
                    default: queue_byte(CH_SPACE, 1'b0);
                endcase
            end
        end else if (kind < 57) begin
            // line comment
            queue_byte(CH_SLASH, 1'b0);
            queue_byte(CH_SLASH, 1'b0);
            n = $urandom_range(0, 8);
            repeat (n) begin
                c = 8'($urandom_range(0, 255));
                queue_byte((c == CH_NEWLINE) ? CH_SPACE : c, 1'b0);
            end
            queue_byte(CH_NEWLINE, 1'b0);
        end else if (kind < 64) begin
            // block comment, star runs inside but no early close
            queue_byte(CH_SLASH, 1'b0);
            queue_byte(CH_STAR, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) begin
                c = ($urandom_range(0, 2) == 0) ? CH_STAR : 8'($urandom_range(0, 255));
                queue_byte((c == CH_SLASH) ? 8'h2E : c, 1'b0);
            end
            queue_byte(CH_STAR, 1'b0);
            queue_byte(CH_SLASH, 1'b0);
        end else if (kind < 76) begin
            // quoted literal with escapes and newlines
            q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
            queue_byte(q, 1'b0);
            n = $urandom_range(0, 6);
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0: begin
                        queue_byte(CH_BACKSLASH, 1'b0);
                        queue_byte($urandom_range(0, 1) ? q : 8'($urandom_range(0, 255)),
                                   1'b0);
                    end
                    1: queue_byte(CH_NEWLINE, 1'b0);
                    default: begin
                        c = 8'($urandom_range(0, 255));
                        queue_byte((c == q || c == CH_BACKSLASH) ? 8'h78 : c, 1'b0);
                    end
                endcase
            end
            queue_byte(q, 1'b0);
        end else if (kind < 81) begin
            // lone slash, the next fragment decides
            queue_byte(CH_SLASH, 1'b0);
        end else if (kind < 91) begin
            n = $urandom_range(1, 3);
            repeat (n) queue_byte(8'($urandom_range(0, 255)), 1'b0);
        end else if (kind < 95) begin
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
        end else begin
            // broken: literal or comment cut off by end of input
            case ($urandom_range(0, 2))
                0: queue_text("/*");
                1: queue_text("//");
                default: queue_byte($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE, 1'b0);
            endcase
            n = $urandom_range(0, 2);
            repeat (n) queue_byte(pick(WORD_SET), 1'b0);
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
        end
    endfunction

    // Offer one request; entered and left at a falling edge
    task automatic send_char(logic [BYTE_W-1:0] c, logic eoi);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid        = 1'b1;
        in_if.in_byte      = c;
        in_if.end_of_input = eoi;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.take_byte(c, eoi);
        @(negedge i_clk);
    endtask

    task automatic send_queued();
        t_src_item it;
        while (src_q.size() != 0) begin
            it = src_q.pop_front();
            send_char(it.ch, it.eoi);
        end
    endtask

    // Sender pause until every owed token has come out
    task automatic wait_for_drain();
        in_if.valid = 1'b0;
        while (sb.awaited_tokens.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    // Result side: random stalls, calm stretches, one long hold-off
    initial begin : result_sink
        int stall;
        out_if.ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (hold_req) begin
                out_if.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end
            stall = rx_calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_if.ready = 1'b1;
            do @(posedge i_clk); while (out_if.valid !== 1'b1 && !hold_req);
            @(negedge i_clk);
        end
    end

    // Check every token byte taken from the block
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            seen_token.out_byte     = out_if.out_byte;
            seen_token.starts_token = out_if.starts_token;
            seen_token.token_class  = t_class'(out_if.token_class);
            seen_token.last_of_run  = out_if.last_of_run;
            sb.check_token(seen_token);
        end
    end

    // Main sequence
    initial begin
        int count;
        int target;
        in_if.valid        = 1'b0;
        in_if.in_byte      = '0;
        in_if.end_of_input = 1'b0;
        tx_calm            = 1'b0;
        rx_calm            = 1'b0;
        hold_req           = 1'b0;
        i_rst_n            = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed text: number into word, operator triple, slash cases,
        // both comment kinds, escaped quote, extreme bytes, flushed slash
        queue_text("1a_+++/x//c\n/**/\"\\\"\";");
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(CH_SLASH, 1'b0);
        queue_byte(8'hA5, 1'b1);
        send_queued();
        wait_for_drain();

        // Random phases: calm, mixed idling, hold-off with full rate, sender gaps
        for (int p = 0; p < 4; p++) begin
            tx_calm = (p == 0) || (p == 2);
            rx_calm = (p == 0) || (p == 2) || (p == 3);
            if (p == 2) hold_req = 1'b1;
            target = (p == 2) ? 160 : 270;
            count  = 0;
            while (count < target) begin
                add_fragment();
                count += src_q.size();
                send_queued();
            end
            send_char(8'($urandom_range(0, 255)), 1'b1);
            wait_for_drain();
        end

        $display("Lexed %0d requests into %0d checked token bytes: directed text,",
                 sb.requests, sb.checked);
        $display("then random fragments under calm, mixed-stall and hold-off traffic.");
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", sb.mismatches);
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Run limit
    initial begin
        #500_000;
        $display("Timeout with %0d token bytes still owed", sb.awaited_tokens.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
